/* hw/rtl/cat_pkg.sv */
// ----------------------------------------------------------------------------
// cat_pkg
// Shared widths, register codes, geometry bundle and multiply helpers for the
// cylinder annulus cell tagger.
// ----------------------------------------------------------------------------
package cat_pkg;

  // Field widths
  localparam int COORD_W        = 32;   // signed Q15.16 coordinate
  localparam int SPACING_W      = 31;   // unsigned Q15.16 cell size
  localparam int RADIUS_W       = 31;   // unsigned Q15.16 radius
  localparam int INDEX_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Arithmetic widths
  localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
  localparam int SQ_W    = 2 * COORD_W;   // square of a difference
  localparam int HALF_W  = DIFF_W;        // split width for wide products
  localparam int NORM_W  = 2 * HALF_W;    // sum of three squares
  localparam int DOT_W   = 2 * DIFF_W + 1; // sum of three signed products
  localparam int WIDE_W  = 2 * NORM_W;    // product of two sums of squares

  // Saturation limits of a cell centre
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Radius slots
  localparam int RAD_OUTER = 0;
  localparam int RAD_INNER = 1;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z,
    REG_OUTER_RADIUS,
    REG_INNER_RADIUS
  } cfg_reg_t;

  // Geometry derived from the registers, held steady between writes
  typedef struct packed {
    logic [2:0][COORD_W-1:0] start;    // axis start per dimension
    logic [2:0][DIFF_W-1:0]  axis;     // end - start, signed
    logic [NORM_W-1:0]       axis_sq;  // |a|^2
    logic [1:0][WIDE_W-1:0]  lim;      // radius^2 * |a|^2, outer and inner
  } geom_t;

  // Signed DIFF_W x DIFF_W product
  function automatic logic [2*DIFF_W-1:0] smul(input logic [DIFF_W-1:0] a,
                                               input logic [DIFF_W-1:0] b);
    logic signed [DIFF_W-1:0]   sa;
    logic signed [DIFF_W-1:0]   sb;
    logic signed [2*DIFF_W-1:0] pr;
    sa = a;
    sb = b;
    pr = sa * sb;
    return pr;
  endfunction

  // Unsigned HALF_W x HALF_W product
  function automatic logic [2*HALF_W-1:0] umul(input logic [HALF_W-1:0] a,
                                               input logic [HALF_W-1:0] b);
    logic [2*HALF_W-1:0] pr;
    pr = a * b;
    return pr;
  endfunction

endpackage

/* hw/rtl/cat_cfg.sv */
// ----------------------------------------------------------------------------
// cat_cfg
// Configuration registers and a short pipeline that derives the axis vector,
// its squared length and the two squared-radius limits scaled by it.
// ----------------------------------------------------------------------------
module cat_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cat_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cat_pkg::geom_t                  geom
);

  // Programmed registers
  logic [2:0][cat_pkg::COORD_W-1:0]  start_r, start_nxt;
  logic [2:0][cat_pkg::COORD_W-1:0]  end_r, end_nxt;
  logic [1:0][cat_pkg::RADIUS_W-1:0] rad_r, rad_nxt;

  // Derived values
  logic [2:0][cat_pkg::DIFF_W-1:0]   axis_r;
  logic [1:0][cat_pkg::NORM_W-1:0]   rsq_r;
  logic [2:0][cat_pkg::SQ_W-1:0]     asq_r;
  logic [cat_pkg::NORM_W-1:0]        magax_r;
  logic [1:0][cat_pkg::NORM_W-1:0]   lpp_ll_r;
  logic [1:0][cat_pkg::NORM_W-1:0]   lpp_lh_r;
  logic [1:0][cat_pkg::NORM_W-1:0]   lpp_hl_r;
  logic [1:0][cat_pkg::NORM_W-1:0]   lpp_hh_r;
  logic [1:0][cat_pkg::NORM_W:0]     lmid_r;
  logic [1:0][cat_pkg::WIDE_W-1:0]   lcat_r;
  logic [1:0][cat_pkg::WIDE_W-1:0]   lim_r;

  logic [2:0][cat_pkg::DIFF_W-1:0]   axis_nxt;
  logic [1:0][cat_pkg::NORM_W-1:0]   rsq_nxt;
  logic [2:0][2*cat_pkg::DIFF_W-1:0] asq_full;
  logic [cat_pkg::NORM_W-1:0]        magax_nxt;
  logic [1:0][cat_pkg::NORM_W-1:0]   lpp_ll_nxt, lpp_lh_nxt, lpp_hl_nxt, lpp_hh_nxt;
  logic [1:0][cat_pkg::NORM_W:0]     lmid_nxt;
  logic [1:0][cat_pkg::WIDE_W-1:0]   lcat_nxt;
  logic [1:0][cat_pkg::WIDE_W-1:0]   lim_nxt;

  // Register write decode
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    rad_nxt   = rad_r;
    if (cfg_we) begin
      unique case (cat_pkg::cfg_reg_t'(cfg_index))
        cat_pkg::REG_START_X:      start_nxt[0] = cfg_data;
        cat_pkg::REG_START_Y:      start_nxt[1] = cfg_data;
        cat_pkg::REG_START_Z:      start_nxt[2] = cfg_data;
        cat_pkg::REG_END_X:        end_nxt[0]   = cfg_data;
        cat_pkg::REG_END_Y:        end_nxt[1]   = cfg_data;
        cat_pkg::REG_END_Z:        end_nxt[2]   = cfg_data;
        cat_pkg::REG_OUTER_RADIUS:
          rad_nxt[cat_pkg::RAD_OUTER] = cfg_data[cat_pkg::RADIUS_W-1:0];
        cat_pkg::REG_INNER_RADIUS:
          rad_nxt[cat_pkg::RAD_INNER] = cfg_data[cat_pkg::RADIUS_W-1:0];
      endcase
    end
  end

  // Axis vector, its squares and the squared radii
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis_nxt[k] = {end_r[k][cat_pkg::COORD_W-1], end_r[k]}
                  - {start_r[k][cat_pkg::COORD_W-1], start_r[k]};
      asq_full[k] = cat_pkg::smul(axis_r[k], axis_r[k]);
    end
    for (int r = 0; r < 2; r++) begin
      rsq_nxt[r] = cat_pkg::umul({2'b00, rad_r[r]}, {2'b00, rad_r[r]});
    end
    magax_nxt = {2'b00, asq_r[0]} + {2'b00, asq_r[1]} + {2'b00, asq_r[2]};
  end

  // Limit = radius^2 * |a|^2, split into four partial products
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      lpp_ll_nxt[r] = cat_pkg::umul(rsq_r[r][cat_pkg::HALF_W-1:0],
                                    magax_r[cat_pkg::HALF_W-1:0]);
      lpp_lh_nxt[r] = cat_pkg::umul(rsq_r[r][cat_pkg::HALF_W-1:0],
                                    magax_r[cat_pkg::NORM_W-1:cat_pkg::HALF_W]);
      lpp_hl_nxt[r] = cat_pkg::umul(rsq_r[r][cat_pkg::NORM_W-1:cat_pkg::HALF_W],
                                    magax_r[cat_pkg::HALF_W-1:0]);
      lpp_hh_nxt[r] = cat_pkg::umul(rsq_r[r][cat_pkg::NORM_W-1:cat_pkg::HALF_W],
                                    magax_r[cat_pkg::NORM_W-1:cat_pkg::HALF_W]);
      lmid_nxt[r]   = {1'b0, lpp_lh_r[r]} + {1'b0, lpp_hl_r[r]};
      lcat_nxt[r]   = {lpp_hh_r[r], lpp_ll_r[r]};
      lim_nxt[r]    = lcat_r[r]
                    + cat_pkg::WIDE_W'({lmid_r[r], {cat_pkg::HALF_W{1'b0}}});
    end
  end

  // All registers clear to the all-zero geometry, which is self-consistent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      rad_r    <= '0;
      axis_r   <= '0;
      rsq_r    <= '0;
      asq_r    <= '0;
      magax_r  <= '0;
      lpp_ll_r <= '0;
      lpp_lh_r <= '0;
      lpp_hl_r <= '0;
      lpp_hh_r <= '0;
      lmid_r   <= '0;
      lcat_r   <= '0;
      lim_r    <= '0;
    end else begin
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      rad_r    <= rad_nxt;
      axis_r   <= axis_nxt;
      rsq_r    <= rsq_nxt;
      for (int k = 0; k < 3; k++) begin
        asq_r[k] <= asq_full[k][cat_pkg::SQ_W-1:0];
      end
      magax_r  <= magax_nxt;
      lpp_ll_r <= lpp_ll_nxt;
      lpp_lh_r <= lpp_lh_nxt;
      lpp_hl_r <= lpp_hl_nxt;
      lpp_hh_r <= lpp_hh_nxt;
      lmid_r   <= lmid_nxt;
      lcat_r   <= lcat_nxt;
      lim_r    <= lim_nxt;
    end
  end

  assign geom.start   = start_r;
  assign geom.axis    = axis_r;
  assign geom.axis_sq = magax_r;
  assign geom.lim     = lim_r;

endmodule

/* hw/rtl/cylinder_annulus_cell_tagger_core.sv */
// ----------------------------------------------------------------------------
// cylinder_annulus_cell_tagger_core
// Tags grid cells whose centre lies inside a cylinder annulus.
// ----------------------------------------------------------------------------
// One request is one grid cell; the block returns one in_region bit for it
// and takes a new request on every clock while in_ready is high.
// The ten stages (centre multiply, centre add and saturate, offset from the
// axis start, dot products, sums, split wide products, two reduction adds,
// the radial subtract, the final compares) each carry a valid bit, and the
// last one is the output register; in_ready only falls when every stage
// holds a request and the output is stalled. Test is exact: the axis
// projection must lie in [0, |a|^2] and |p|^2*|a|^2 - (p.a)^2 between
// inner^2*|a|^2 and outer^2*|a|^2; a zero-length axis never tags. Values
// derived from the registers settle after a write before any request accepted
// with or after that write can reach the points that use them.
// ----------------------------------------------------------------------------
module cylinder_annulus_cell_tagger_core #(
  parameter int INDEX_BITS = cat_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [INDEX_BITS-1:0]               in_cell_i,
  input  logic [INDEX_BITS-1:0]               in_cell_j,
  input  logic [INDEX_BITS-1:0]               in_cell_k,
  input  logic signed [cat_pkg::COORD_W-1:0]  in_origin_x,
  input  logic signed [cat_pkg::COORD_W-1:0]  in_origin_y,
  input  logic signed [cat_pkg::COORD_W-1:0]  in_origin_z,
  input  logic [cat_pkg::SPACING_W-1:0]       in_spacing_x,
  input  logic [cat_pkg::SPACING_W-1:0]       in_spacing_y,
  input  logic [cat_pkg::SPACING_W-1:0]       in_spacing_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_in_region,
  // configuration
  input  logic                                cfg_we,
  input  logic [cat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cat_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NUM_ST  = 10;
  localparam int ODD_W   = INDEX_BITS + 1;
  localparam int PROD_W  = ODD_W + cat_pkg::SPACING_W;
  localparam int HALFP_W = PROD_W - 1;
  localparam int SUM_W   = HALFP_W + 2;

  cat_pkg::geom_t geom;

  cat_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // --------------------------------------------------------------------------
  // Stage control: stage g loads when out_ready is high or any stage from g onwards is free
  // --------------------------------------------------------------------------
  logic [NUM_ST:1] v_r, v_nxt;
  logic [NUM_ST:1] en;

  for (genvar g = 1; g <= NUM_ST; g++) begin : g_en
    assign en[g] = out_ready || !(&v_r[NUM_ST:g]);
  end

  always_comb begin
    v_nxt = v_r;
    if (en[1]) v_nxt[1] = in_valid;
    for (int k = 2; k <= NUM_ST; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NUM_ST];

  // --------------------------------------------------------------------------
  // Stage 1: (2*index + 1) * spacing
  // --------------------------------------------------------------------------
  logic [2:0][INDEX_BITS-1:0]          idx;
  logic [2:0][cat_pkg::COORD_W-1:0]    org;
  logic [2:0][cat_pkg::SPACING_W-1:0]  spc;
  logic [2:0][PROD_W-1:0]              s1_prod_nxt;
  logic [2:0][PROD_W-1:0]              s1_prod_r;
  logic [2:0][cat_pkg::COORD_W-1:0]    s1_org_r;

  always_comb begin
    idx = {in_cell_k, in_cell_j, in_cell_i};
    org = {in_origin_z, in_origin_y, in_origin_x};
    spc = {in_spacing_z, in_spacing_y, in_spacing_x};
    for (int k = 0; k < 3; k++) begin
      s1_prod_nxt[k] = PROD_W'({idx[k], 1'b1}) * PROD_W'(spc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod_r <= s1_prod_nxt;
      s1_org_r  <= org;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: centre = origin + half product, saturated to the coordinate range
  // --------------------------------------------------------------------------
  logic [2:0][SUM_W-1:0]            cen_sum;
  logic [2:0][cat_pkg::COORD_W-1:0] s2_cen_nxt;
  logic [2:0][cat_pkg::COORD_W-1:0] s2_cen_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cen_sum[k] = {{(SUM_W-cat_pkg::COORD_W){s1_org_r[k][cat_pkg::COORD_W-1]}},
                    s1_org_r[k]}
                 + {2'b00, s1_prod_r[k][PROD_W-1:1]};
      // upper bits all equal: value fits the coordinate width
      if ((&cen_sum[k][SUM_W-1:cat_pkg::COORD_W-1]) ||
          !(|cen_sum[k][SUM_W-1:cat_pkg::COORD_W-1])) begin
        s2_cen_nxt[k] = cen_sum[k][cat_pkg::COORD_W-1:0];
      end else if (cen_sum[k][SUM_W-1]) begin
        s2_cen_nxt[k] = cat_pkg::COORD_MIN;
      end else begin
        s2_cen_nxt[k] = cat_pkg::COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) s2_cen_r <= s2_cen_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: p = centre - start
  // --------------------------------------------------------------------------
  logic [2:0][cat_pkg::DIFF_W-1:0] s3_p_nxt;
  logic [2:0][cat_pkg::DIFF_W-1:0] s3_p_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_p_nxt[k] = {s2_cen_r[k][cat_pkg::COORD_W-1], s2_cen_r[k]}
                  - {geom.start[k][cat_pkg::COORD_W-1], geom.start[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) s3_p_r <= s3_p_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 4: per-axis products p*a and p*p
  // --------------------------------------------------------------------------
  logic [2:0][2*cat_pkg::DIFF_W-1:0] pa_nxt;
  logic [2:0][2*cat_pkg::DIFF_W-1:0] pq_full;
  logic [2:0][2*cat_pkg::DIFF_W-1:0] s4_pa_r;
  logic [2:0][cat_pkg::SQ_W-1:0]     s4_pq_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_nxt[k]  = cat_pkg::smul(s3_p_r[k], geom.axis[k]);
      pq_full[k] = cat_pkg::smul(s3_p_r[k], s3_p_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_pa_r <= pa_nxt;
      for (int k = 0; k < 3; k++) begin
        s4_pq_r[k] <= pq_full[k][cat_pkg::SQ_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: dot product p.a and squared length |p|^2
  // --------------------------------------------------------------------------
  localparam int PA_W = 2 * cat_pkg::DIFF_W;

  logic [cat_pkg::DOT_W-1:0]  s5_dot_nxt, s5_dot_r;
  logic [cat_pkg::NORM_W-1:0] s5_norm_nxt, s5_norm_r;

  always_comb begin
    s5_dot_nxt  = {s4_pa_r[0][PA_W-1], s4_pa_r[0]}
                + {s4_pa_r[1][PA_W-1], s4_pa_r[1]}
                + {s4_pa_r[2][PA_W-1], s4_pa_r[2]};
    s5_norm_nxt = {2'b00, s4_pq_r[0]} + {2'b00, s4_pq_r[1]} + {2'b00, s4_pq_r[2]};
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_dot_r  <= s5_dot_nxt;
      s5_norm_r <= s5_norm_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: axial window check and split products |p|^2*|a|^2, (p.a)^2
  // --------------------------------------------------------------------------
  localparam int HW = cat_pkg::HALF_W;
  localparam int NW = cat_pkg::NORM_W;

  logic [NW-1:0] dot_mag;
  logic          s6_ok_nxt, s6_ok_r;
  logic [NW-1:0] s6_nm_ll_r, s6_nm_lh_r, s6_nm_hl_r, s6_nm_hh_r;
  logic [NW-1:0] s6_dd_ll_r, s6_dd_lh_r, s6_dd_hh_r;

  always_comb begin
    dot_mag   = s5_dot_r[NW-1:0];
    s6_ok_nxt = (geom.axis_sq != '0) && !s5_dot_r[cat_pkg::DOT_W-1]
             && (dot_mag <= geom.axis_sq);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_ok_r    <= s6_ok_nxt;
      s6_nm_ll_r <= cat_pkg::umul(s5_norm_r[HW-1:0], geom.axis_sq[HW-1:0]);
      s6_nm_lh_r <= cat_pkg::umul(s5_norm_r[HW-1:0], geom.axis_sq[NW-1:HW]);
      s6_nm_hl_r <= cat_pkg::umul(s5_norm_r[NW-1:HW], geom.axis_sq[HW-1:0]);
      s6_nm_hh_r <= cat_pkg::umul(s5_norm_r[NW-1:HW], geom.axis_sq[NW-1:HW]);
      s6_dd_ll_r <= cat_pkg::umul(dot_mag[HW-1:0], dot_mag[HW-1:0]);
      s6_dd_lh_r <= cat_pkg::umul(dot_mag[HW-1:0], dot_mag[NW-1:HW]);
      s6_dd_hh_r <= cat_pkg::umul(dot_mag[NW-1:HW], dot_mag[NW-1:HW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: middle terms summed, outer terms concatenated
  // --------------------------------------------------------------------------
  localparam int WW = cat_pkg::WIDE_W;

  logic          s7_ok_r;
  logic [NW:0]   s7_nm_mid_r;
  logic [NW-1:0] s7_dd_mid_r;
  logic [WW-1:0] s7_nm_cat_r, s7_dd_cat_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_ok_r     <= s6_ok_r;
      s7_nm_mid_r <= {1'b0, s6_nm_lh_r} + {1'b0, s6_nm_hl_r};
      s7_dd_mid_r <= s6_dd_lh_r;
      s7_nm_cat_r <= {s6_nm_hh_r, s6_nm_ll_r};
      s7_dd_cat_r <= {s6_dd_hh_r, s6_dd_ll_r};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: full products; the cross term of the square counts twice
  // --------------------------------------------------------------------------
  logic          s8_ok_r;
  logic [WW-1:0] s8_nm_r, s8_dd_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_ok_r <= s7_ok_r;
      s8_nm_r <= s7_nm_cat_r + WW'({s7_nm_mid_r, {HW{1'b0}}});
      s8_dd_r <= s7_dd_cat_r + WW'({s7_dd_mid_r, {(HW+1){1'b0}}});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: radial term |p|^2*|a|^2 - (p.a)^2
  // --------------------------------------------------------------------------
  logic          s9_ok_r;
  logic [WW-1:0] s9_lhs_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_ok_r  <= s8_ok_r;
      s9_lhs_r <= s8_nm_r - s8_dd_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10 (output register): radial window check
  // --------------------------------------------------------------------------
  logic s10_hit_nxt, s10_hit_r;

  always_comb begin
    s10_hit_nxt = s9_ok_r
               && (s9_lhs_r <= geom.lim[cat_pkg::RAD_OUTER])
               && (s9_lhs_r >= geom.lim[cat_pkg::RAD_INNER]);
  end

  always_ff @(posedge clk) begin
    if (en[NUM_ST]) s10_hit_r <= s10_hit_nxt;
  end

  assign out_in_region = s10_hit_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[1])
    else $error("accepted request did not reach the first stage");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !en[2] |=> v_r[1] && $stable(s1_prod_r))
    else $error("first stage lost or changed a stalled request");

  a_axial_reject: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[9] && en[NUM_ST] && !s9_ok_r |=> !s10_hit_r)
    else $error("cell outside the axial window was tagged");

endmodule

/* verif/cylinder_annulus_cell_tagger_core_tb.sv */
// ----------------------------------------------------------------------------
// cylinder_annulus_cell_tagger_core_tb
// Self-checking bench for the cylinder annulus cell tagger.
// ----------------------------------------------------------------------------
// Grid cells are pushed through the request channel under a series of cylinder
// settings. Each in_region bit is predicted with exact 192-bit integer
// arithmetic and checked in order against what the block returns. Both
// channels gap and stall at random; the result side also holds off twice for a
// long stretch. The block is drained before every settings change.
// ----------------------------------------------------------------------------
module cylinder_annulus_cell_tagger_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cat_pkg::*;

  localparam int     IDX_W       = INDEX_BITS_DEF;
  localparam int     LATENCY     = 10;
  localparam int     LONG_HOLD   = 80;
  localparam int     PHASE_ITEMS = 160;
  localparam int     N_PHASES    = 10;
  localparam longint SPAN        = 64'sd1 << 28;
  // boundary bar along x: length 16.0, outer 2.0, inner 1.0
  localparam longint BAR_LEN     = 64'sd1048576;
  localparam longint BAR_OUT     = 64'sd131072;
  localparam longint BAR_IN      = 64'sd65536;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [2:0][IDX_W-1:0]     idx;
    logic [2:0][COORD_W-1:0]   org;
    logic [2:0][SPACING_W-1:0] spc;
  } cell_req_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] base;
    logic [2:0][COORD_W-1:0] tip;
    logic [CFG_DATA_W-1:0]   outer;
    logic [CFG_DATA_W-1:0]   inner;
  } cyl_geom_t;

  typedef enum int {
    GEOM_AXIAL,
    GEOM_SLANT,
    GEOM_WIDE,
    GEOM_CROSSED,
    GEOM_POINT
  } geom_kind_t;

  // Shadow geometry, in_region predictor and queue of tags still owed
  class annulus_checker;
    localparam int     SHOWN = 10;
    localparam longint C_HI  = 64'sh7FFF_FFFF;
    localparam longint C_LO  = -64'sh8000_0000;

    longint base_c[3];
    longint tip_c[3];
    longint outer_r;
    longint inner_r;
    bit     tag_due[$];
    int     n_seen;
    int     n_bad;

    static function longint clamp_coord(longint v);
      if (v > C_HI) return C_HI;
      if (v < C_LO) return C_LO;
      return v;
    endfunction

    // (index + 0.5) * spacing with the half LSB dropped
    static function longint half_step(logic [IDX_W-1:0] i, logic [SPACING_W-1:0] s);
      return ((2 * longint'(i) + 1) * longint'(s)) >>> 1;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_START_X:      base_c[0] = longint'(signed'(d));
        REG_START_Y:      base_c[1] = longint'(signed'(d));
        REG_START_Z:      base_c[2] = longint'(signed'(d));
        REG_END_X:        tip_c[0]  = longint'(signed'(d));
        REG_END_Y:        tip_c[1]  = longint'(signed'(d));
        REG_END_Z:        tip_c[2]  = longint'(signed'(d));
        REG_OUTER_RADIUS: outer_r   = longint'(d[RADIUS_W-1:0]);
        REG_INNER_RADIUS: inner_r   = longint'(d[RADIUS_W-1:0]);
        default: ;
      endcase
    endfunction

    function bit predict_tag(cell_req_t c);
      wide_t  dot, mag, pp, p, a, lhs, lim_o, lim_i;
      longint ctr;
      int     k;
      dot = 0;
      mag = 0;
      pp  = 0;
      for (k = 0; k < 3; k++) begin
        ctr = clamp_coord(longint'(signed'(c.org[k])) + half_step(c.idx[k], c.spc[k]));
        p   = wide_t'(ctr - base_c[k]);
        a   = wide_t'(tip_c[k] - base_c[k]);
        dot += p * a;
        mag += a * a;
        pp  += p * p;
      end
      // zero-length axis or projection outside the segment
      if (mag <= 0 || dot < 0 || dot > mag) return 1'b0;
      // radial test scaled by |a|^2 to stay exact
      lhs   = pp * mag - dot * dot;
      lim_o = wide_t'(outer_r * outer_r) * mag;
      lim_i = wide_t'(inner_r * inner_r) * mag;
      return (lhs <= lim_o) && (lhs >= lim_i);
    endfunction

    function void note_cell(cell_req_t c);
      tag_due.push_back(predict_tag(c));
    endfunction

    function void check_tag(logic got);
      bit want;
      n_seen++;
      if (tag_due.size() == 0) begin
        n_bad++;
        if (n_bad <= SHOWN)
          $display("[%0t] result with nothing owed: in_region=%b", $time, got);
        return;
      end
      want = tag_due.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= SHOWN)
          $display("[%0t] in_region mismatch on result %0d: expected %b, got %b",
                   $time, n_seen, want, got);
      end
    endfunction

    function int pending();
      return tag_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [IDX_W-1:0]       in_cell_i;
  logic [IDX_W-1:0]       in_cell_j;
  logic [IDX_W-1:0]       in_cell_k;
  logic signed [COORD_W-1:0] in_origin_x;
  logic signed [COORD_W-1:0] in_origin_y;
  logic signed [COORD_W-1:0] in_origin_z;
  logic [SPACING_W-1:0]   in_spacing_x;
  logic [SPACING_W-1:0]   in_spacing_y;
  logic [SPACING_W-1:0]   in_spacing_z;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_in_region;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  annulus_checker sb;
  bit             idle_on = 1'b1;

  geom_kind_t phase_plan [N_PHASES] = '{GEOM_AXIAL, GEOM_SLANT, GEOM_WIDE, GEOM_AXIAL,
                                        GEOM_CROSSED, GEOM_SLANT, GEOM_POINT, GEOM_AXIAL,
                                        GEOM_WIDE, GEOM_SLANT};

  cylinder_annulus_cell_tagger_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cell_i    (in_cell_i),
    .in_cell_j    (in_cell_j),
    .in_cell_k    (in_cell_k),
    .in_origin_x  (in_origin_x),
    .in_origin_y  (in_origin_y),
    .in_origin_z  (in_origin_z),
    .in_spacing_x (in_spacing_x),
    .in_spacing_y (in_spacing_y),
    .in_spacing_z (in_spacing_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_in_region(out_in_region),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Uniform pick in [lo, hi], spans wider than 32 bits allowed
  function automatic longint rand_span(longint lo, longint hi);
    longint r;
    r = longint'({$urandom, $urandom} >> 1);
    return lo + r % (hi - lo + 1);
  endfunction

  // Cell whose centre lands on (x, y, z): random index and spacing, origin backed out
  function automatic cell_req_t place_cell(longint x, longint y, longint z, int spc_max);
    cell_req_t c;
    longint    want [3];
    int        k;
    want[0] = x;
    want[1] = y;
    want[2] = z;
    for (k = 0; k < 3; k++) begin
      c.idx[k] = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      c.spc[k] = SPACING_W'($urandom_range(0, spc_max));
      c.org[k] = COORD_W'(annulus_checker::clamp_coord(
                   want[k] - annulus_checker::half_step(c.idx[k], c.spc[k])));
    end
    return c;
  endfunction

  // Centre near the segment, a little past both ends, within 1.5 outer radii per axis
  function automatic cell_req_t aim_cell(cyl_geom_t g);
    longint t, rad, a, b;
    longint pt [3];
    int     k;
    t   = rand_span(-100, 1124);
    rad = longint'(g.outer[RADIUS_W-1:0]) * 3 / 2 + 4;
    for (k = 0; k < 3; k++) begin
      b     = longint'(signed'(g.base[k]));
      a     = longint'(signed'(g.tip[k])) - b;
      pt[k] = b + (a * t) / 1024 + rand_span(-rad, rad);
    end
    return place_cell(pt[0], pt[1], pt[2], 4095);
  endfunction

  function automatic cell_req_t random_cell();
    cell_req_t c;
    int        k;
    for (k = 0; k < 3; k++) begin
      c.idx[k] = IDX_W'($urandom);
      c.org[k] = $urandom;
      c.spc[k] = SPACING_W'($urandom);
    end
    return c;
  endfunction

  function automatic cyl_geom_t make_geom(geom_kind_t kind);
    cyl_geom_t g;
    longint    ro, ri, len;
    int        ax, k;
    ro = rand_span(1, 64'sd1 << 26);
    ri = ($urandom_range(0, 1) == 1) ? 0 : rand_span(0, ro);
    ax = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      g.base[k] = COORD_W'(rand_span(-SPAN, SPAN));
      g.tip[k]  = COORD_W'(rand_span(-SPAN, SPAN));
    end
    case (kind)
      GEOM_AXIAL: begin
        len = rand_span(1, SPAN);
        for (k = 0; k < 3; k++) g.tip[k] = g.base[k];
        g.tip[ax] = COORD_W'(longint'(signed'(g.base[ax])) +
                             (($urandom_range(0, 1) == 1) ? len : -len));
      end
      GEOM_WIDE: begin
        for (k = 0; k < 3; k++) begin
          g.base[k] = $urandom;
          g.tip[k]  = $urandom;
        end
        ro = $urandom_range(0, 32'h7FFF_FFFF);
        ri = ($urandom_range(0, 1) == 1) ? 0 : rand_span(0, ro);
      end
      GEOM_CROSSED: ri = ro + rand_span(1, ro);
      GEOM_POINT: begin
        for (k = 0; k < 3; k++) g.tip[k] = g.base[k];
      end
      default: ;
    endcase
    // top bit of a radius write is not part of the register
    g.outer = {1'($urandom_range(0, 1)), RADIUS_W'(ro)};
    g.inner = {1'($urandom_range(0, 1)), RADIUS_W'(ri)};
    return g;
  endfunction

  task automatic put_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(r, d);
  endtask

  // Only called with nothing in flight
  task automatic load_geom(cyl_geom_t g);
    put_reg(REG_START_X, g.base[0]);
    put_reg(REG_START_Y, g.base[1]);
    put_reg(REG_START_Z, g.base[2]);
    put_reg(REG_END_X, g.tip[0]);
    put_reg(REG_END_Y, g.tip[1]);
    put_reg(REG_END_Z, g.tip[2]);
    put_reg(REG_OUTER_RADIUS, g.outer);
    put_reg(REG_INNER_RADIUS, g.inner);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request, holding it until taken
  task automatic push_cell(cell_req_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cell_i    <= c.idx[0];
    in_cell_j    <= c.idx[1];
    in_cell_k    <= c.idx[2];
    in_origin_x  <= c.org[0];
    in_origin_y  <= c.org[1];
    in_origin_z  <= c.org[2];
    in_spacing_x <= c.spc[0];
    in_spacing_y <= c.spc[1];
    in_spacing_z <= c.spc[2];
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Stop offering until every owed tag is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Watch both handshakes; values read here are the ones before the edge
  always @(posedge clk) begin : watch
    cell_req_t seen;
    if (rst_n && in_valid && in_ready) begin
      seen.idx[0] = in_cell_i;
      seen.idx[1] = in_cell_j;
      seen.idx[2] = in_cell_k;
      seen.org[0] = in_origin_x;
      seen.org[1] = in_origin_y;
      seen.org[2] = in_origin_z;
      seen.spc[0] = in_spacing_x;
      seen.spc[1] = in_spacing_y;
      seen.spc[2] = in_spacing_z;
      sb.note_cell(seen);
    end
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_tag(out_in_region);
  end

  // Result side: short random stalls, two long hold-offs to back the pipe up
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ((holds_done == 0 && sb.n_seen >= 300) ||
          (holds_done == 1 && sb.n_seen >= 1000)) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    cyl_geom_t g;
    cell_req_t c;
    int        ph, n;
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cell_i    <= '0;
    in_cell_j    <= '0;
    in_cell_k    <= '0;
    in_origin_x  <= '0;
    in_origin_y  <= '0;
    in_origin_z  <= '0;
    in_spacing_x <= '0;
    in_spacing_y <= '0;
    in_spacing_z <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero-length axis never tags; field extremes
    push_cell(place_cell(0, 0, 0, 255));
    c = '0;
    c.org = {3{COORD_MIN}};
    push_cell(c);
    c = '1;
    c.org = {3{COORD_MAX}};
    push_cell(c);
    drain();

    // bar along x: exact ends of the segment and exact radii
    g = '0;
    g.tip[0] = COORD_W'(BAR_LEN);
    g.outer  = CFG_DATA_W'(BAR_OUT);
    g.inner  = CFG_DATA_W'(BAR_IN);
    load_geom(g);
    push_cell(place_cell(0, BAR_OUT, 0, 255));
    push_cell(place_cell(BAR_LEN, 0, -BAR_IN, 255));
    push_cell(place_cell(-1, BAR_OUT, 0, 255));
    push_cell(place_cell(BAR_LEN + 1, 0, BAR_OUT, 255));
    push_cell(place_cell(BAR_LEN / 2, BAR_OUT + 1, 0, 255));
    push_cell(place_cell(BAR_LEN / 2, 0, BAR_IN - 1, 255));
    push_cell(place_cell(BAR_LEN / 2, 0, 0, 255));
    push_cell(place_cell(BAR_LEN / 2, 100000, -50000, 255));
    // zero spacing: centre sits on the origin
    push_cell(place_cell(BAR_LEN / 3, 0, BAR_OUT, 0));
    drain();

    // axis ending at the top of the range: saturated centres land on its end
    g = '0;
    g.base[0] = 32'h7FFF_0000;
    g.tip[0]  = COORD_MAX;
    g.outer   = 32'h0000_0100;
    load_geom(g);
    c = place_cell(0, 0, 0, 255);
    c.idx[0] = '1;
    c.spc[0] = '1;
    c.org[0] = 32'h7FF0_0000;
    push_cell(c);
    c.org[0] = COORD_MIN;
    push_cell(c);
    push_cell(place_cell(64'sh7FFF_8000, 64'sh80, 0, 255));
    drain();

    // full diagonal of the range, largest radii, inner equal to outer
    g.base   = {3{COORD_MIN}};
    g.tip    = {3{COORD_MAX}};
    g.outer  = 32'hFFFF_FFFF;
    g.inner  = 32'h7FFF_FFFF;
    load_geom(g);
    push_cell(place_cell(0, 0, 0, 255));
    push_cell(random_cell());
    push_cell(aim_cell(g));
    push_cell(aim_cell(g));
    drain();

    // random phases, each under fresh settings; last one runs without gaps
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph == N_PHASES - 1) idle_on = 1'b0;
      g = make_geom(phase_plan[ph]);
      load_geom(g);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) push_cell(random_cell());
        else push_cell(aim_cell(g));
      end
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    if (sb.n_bad == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
